@@ rtl/ftms_pkg.sv @@
// Shared types, constants and helpers of the flow template match scorer.
`default_nettype none

package ftms_pkg;

    localparam int DEPTH = 64;
    localparam int IDX_W = 6;
    localparam int LEN_W = 7;

    // configuration register indexes
    localparam logic [2:0] CFG_WINDOW_LENGTH    = 3'd0;
    localparam logic [2:0] CFG_MARKER_CELL_SIZE = 3'd1;
    localparam logic [2:0] CFG_AVERAGE_GAIN     = 3'd2;
    localparam logic [2:0] CFG_MARKER_THRESHOLD = 3'd3;
    localparam logic [2:0] CFG_MATCH_THRESHOLD  = 3'd4;

    // opcodes
    localparam logic OP_PACKET   = 1'b0;
    localparam logic OP_TEMPLATE = 1'b1;

    // reset values
    localparam logic [6:0]  RST_WINDOW_LENGTH    = 7'd64;
    localparam logic [15:0] RST_MARKER_CELL_SIZE = 16'd586;
    localparam logic [15:0] RST_AVERAGE_GAIN     = 16'd6554;
    localparam logic [15:0] RST_MARKER_THRESHOLD = 16'd26214;

    localparam logic signed [47:0] MAX48 = 48'sh7FFF_FFFF_FFFF;
    localparam logic signed [47:0] MIN48 = 48'sh8000_0000_0000;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MARK_MUL,
        S_MARK_UPD,
        S_FETCH,
        S_CUM,
        S_SQ,
        S_LO,
        S_HI,
        S_PEN,
        S_APPLY,
        S_FINISH,
        S_DONE
    } state_t;

    typedef struct packed {
        logic [23:0] op_a;
        logic [23:0] op_b;
    } mul_req_t;

    typedef struct packed {
        logic signed [23:0] bias;
        logic [23:0]        scale_out;
        logic [23:0]        scale_in;
        logic [21:0]        mean_out;
        logic [21:0]        mean_in;
    } tmpl_entry_t;

    typedef struct packed {
        logic        outgoing;
        logic [15:0] size;
    } ring_entry_t;

    function automatic logic signed [47:0] sat48(input logic signed [53:0] v);
        logic signed [47:0] r;
        if (v > 54'(MAX48)) begin
            r = MAX48;
        end else if (v < 54'(MIN48)) begin
            r = MIN48;
        end else begin
            r = v[47:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

@@ rtl/ftms_mul.sv @@
// Shared 24x24 unsigned multiplier with registered product.
`default_nettype none

module ftms_mul
    import ftms_pkg::*;
(
    input  wire logic        aclk,
    input  wire mul_req_t    req,
    output logic [47:0]      prod
);

    logic [47:0] prod_reg;

    always_ff @(posedge aclk) begin
        prod_reg <= req.op_a * req.op_b;
    end

    assign prod = prod_reg;

endmodule

`default_nettype wire

@@ rtl/flow_template_match_scorer.sv @@
// Top level: packet ring, template store, marker average and window scorer.
//
// Each transaction on the slave side is either a packet event (tuser = 0) or a
// template entry write (tuser = 1); every one yields exactly one transaction
// on the master side. A template write goes from acceptance straight to the
// result. A packet event first updates the marker-cell average. Once the
// marker flag is set and the ring holds a full window, the packet scores the
// window over all L positions, L being the active window length. The walk is
// paced by the single shared 24x24 multiplier, which is used three times for
// each of the two error terms at every window position (square, then low and
// high partial products of the scale multiply), followed by a penalty add and
// a saturating accumulate. The slave side is ready only while the sequencer
// is idle; a finished result sits in the output register, so a new transaction
// can be taken while the previous result waits for m_tready. Template entries
// read before they are written return unspecified data.
`default_nettype none

module flow_template_match_scorer
    import ftms_pkg::*;
(
    input  wire logic         aclk,
    input  wire logic         aresetn,
    // config write port
    input  wire logic         cfg_we,
    input  wire logic [2:0]   cfg_addr,
    input  wire logic [47:0]  cfg_wdata,
    // slave side
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // [15:0] payload_size, [16] is_outgoing, [22:17] entry_index,
    // [44:23] entry_mean_in, [66:45] entry_mean_out, [90:67] entry_scale_in,
    // [114:91] entry_scale_out, [138:115] entry_bias, [143:139] zero
    input  wire logic [143:0] s_tdata,
    // [0] opcode
    input  wire logic         s_tuser,
    // master side
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // [0] marker_seen, [1] match_flag, [49:2] match_score,
    // [97:50] best_score, [103:98] zero
    output logic [103:0]      m_tdata,
    // [0] score_valid
    output logic              m_tuser
);

    // ---------------- configuration registers ----------------
    logic [6:0]         wl_reg;
    logic [15:0]        mcs_reg;
    logic [15:0]        gain_reg;
    logic [15:0]        mthr_reg;
    logic signed [47:0] xthr_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wl_reg   <= RST_WINDOW_LENGTH;
            mcs_reg  <= RST_MARKER_CELL_SIZE;
            gain_reg <= RST_AVERAGE_GAIN;
            mthr_reg <= RST_MARKER_THRESHOLD;
            xthr_reg <= '0;
        end else if (cfg_we) begin
            case (cfg_addr)
                CFG_WINDOW_LENGTH:    wl_reg   <= cfg_wdata[6:0];
                CFG_MARKER_CELL_SIZE: mcs_reg  <= cfg_wdata[15:0];
                CFG_AVERAGE_GAIN:     gain_reg <= cfg_wdata[15:0];
                CFG_MARKER_THRESHOLD: mthr_reg <= cfg_wdata[15:0];
                CFG_MATCH_THRESHOLD:  xthr_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // active window length, clamped to 1..DEPTH
    logic [LEN_W-1:0] len_act;
    always_comb begin
        if (wl_reg == '0) begin
            len_act = LEN_W'(1);
        end else if (wl_reg > LEN_W'(DEPTH)) begin
            len_act = LEN_W'(DEPTH);
        end else begin
            len_act = wl_reg;
        end
    end

    // ---------------- input field decode ----------------
    logic        in_op;
    logic [15:0] in_size;
    logic        in_outg;
    tmpl_entry_t in_entry;
    logic [IDX_W-1:0] in_idx;

    assign in_op              = s_tuser;
    assign in_size            = s_tdata[15:0];
    assign in_outg            = s_tdata[16];
    assign in_idx             = s_tdata[22:17];
    assign in_entry.mean_in   = s_tdata[44:23];
    assign in_entry.mean_out  = s_tdata[66:45];
    assign in_entry.scale_in  = s_tdata[90:67];
    assign in_entry.scale_out = s_tdata[114:91];
    assign in_entry.bias      = s_tdata[138:115];

    logic accept;
    assign accept = s_tvalid && s_tready;

    // ---------------- state ----------------
    state_t state_reg, state_next;

    logic [IDX_W-1:0]   wp_reg, wp_next;       // ring write pointer
    logic [LEN_W-1:0]   ps_reg, ps_next;       // packets seen, saturating
    logic [15:0]        level_reg, level_next; // marker average, Q0.16
    logic               flag_reg, flag_next;   // sticky marker flag
    logic               match_reg, match_next;
    logic signed [47:0] top_reg, top_next;
    logic               hit_reg, hit_next;
    logic [IDX_W-1:0]   i_reg, i_next;         // template position
    logic [IDX_W-1:0]   j_reg, j_next;         // ring position
    logic               phase_reg, phase_next; // 0 inbound term, 1 outbound term
    logic [21:0]        cin_reg, cin_next;
    logic [21:0]        cout_reg, cout_next;
    logic signed [47:0] sum_reg, sum_next;
    logic [21:0]        e2hi_reg, e2hi_next;
    logic [46:0]        acc_reg, acc_next;
    logic [51:0]        pen_reg, pen_next;
    logic               res_valid_reg, res_valid_next;
    logic               m_valid_reg, m_valid_next;
    logic [103:0]       m_data_reg, m_data_next;
    logic               m_user_reg, m_user_next;

    // ---------------- memories ----------------
    ring_entry_t ring_mem [DEPTH];
    logic [DEPTH-1:0] ring_vld_reg;
    ring_entry_t ring_rd_reg;
    logic        ring_rd_vld_reg;
    tmpl_entry_t tmpl_mem [DEPTH];
    tmpl_entry_t tmpl_rd_reg;

    logic             pkt_wr;
    logic [IDX_W-1:0] wp_eff;
    ring_entry_t      pkt_entry;

    assign pkt_wr             = accept && (in_op == OP_PACKET);
    assign wp_eff             = ({1'b0, wp_reg} >= len_act) ? '0 : wp_reg;
    assign pkt_entry.outgoing = in_outg;
    assign pkt_entry.size     = in_size;

    always_ff @(posedge aclk) begin
        if (pkt_wr) begin
            ring_mem[wp_eff] <= pkt_entry;
        end
        ring_rd_reg <= ring_mem[j_reg];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ring_vld_reg    <= '0;
            ring_rd_vld_reg <= 1'b0;
        end else begin
            if (pkt_wr) begin
                ring_vld_reg[wp_eff] <= 1'b1;
            end
            ring_rd_vld_reg <= ring_vld_reg[j_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && (in_op == OP_TEMPLATE)) begin
            tmpl_mem[in_idx] <= in_entry;
        end
        tmpl_rd_reg <= tmpl_mem[i_reg];
    end

    // ---------------- shared multiplier ----------------
    mul_req_t    mul_req;
    logic [47:0] mul_prod;

    ftms_mul u_mul (
        .aclk (aclk),
        .req  (mul_req),
        .prod (mul_prod)
    );

    // ---------------- walk helpers ----------------
    logic              last_pos;
    logic [IDX_W-1:0]  j_step;
    logic [IDX_W:0]    j_inc;
    logic [21:0]       sel_mean, sel_cum;
    logic [23:0]       sel_scale;
    logic [22:0]       err;
    logic [21:0]       err_abs;
    ring_entry_t       pkt_rd;
    logic [IDX_W:0]    wp_inc;

    assign last_pos  = ({1'b0, i_reg} == (len_act - LEN_W'(1)));
    assign j_inc     = {1'b0, j_reg} + LEN_W'(1);
    assign j_step    = (j_inc >= len_act) ? '0 : j_inc[IDX_W-1:0];
    assign sel_mean  = phase_reg ? tmpl_rd_reg.mean_out  : tmpl_rd_reg.mean_in;
    assign sel_cum   = phase_reg ? cout_reg : cin_reg;
    assign sel_scale = phase_reg ? tmpl_rd_reg.scale_out : tmpl_rd_reg.scale_in;
    assign err       = {1'b0, sel_mean} - {1'b0, sel_cum};
    assign err_abs   = err[22] ? 22'(-err) : err[21:0];
    assign pkt_rd    = ring_rd_vld_reg ? ring_rd_reg : '0;
    assign wp_inc    = {1'b0, wp_eff} + LEN_W'(1);

    // marker average update terms
    logic [16:0] gain_comp;
    logic [33:0] lv_sum;
    logic [15:0] lv_sat;
    assign gain_comp = 17'h1_0000 - {1'b0, gain_reg};
    assign lv_sum    = {1'b0, mul_prod[32:0]} + 34'd32768
                     + (hit_reg ? {2'b0, gain_reg, 16'b0} : 34'd0);
    assign lv_sat    = (lv_sum[33:32] != 2'b00) ? 16'hFFFF : lv_sum[31:16];

    // penalty: (e^2 * scale + 2^15) >> 16 from two partial products
    logic [67:0] pen_full;
    assign pen_full = {21'b0, acc_reg} + {mul_prod[45:0], 22'b0};

    // ---------------- next state ----------------
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    state_next = (in_op == OP_PACKET) ? S_MARK_MUL : S_DONE;
                end
            end
            S_MARK_MUL: state_next = S_MARK_UPD;
            S_MARK_UPD: begin
                if ((flag_reg || (lv_sat > mthr_reg)) && (ps_reg >= len_act)) begin
                    state_next = S_FETCH;
                end else begin
                    state_next = S_DONE;
                end
            end
            S_FETCH: state_next = S_CUM;
            S_CUM:   state_next = S_SQ;
            S_SQ:    state_next = S_LO;
            S_LO:    state_next = S_HI;
            S_HI:    state_next = S_PEN;
            S_PEN:   state_next = S_APPLY;
            S_APPLY: begin
                if (!phase_reg) begin
                    state_next = S_SQ;
                end else if (last_pos) begin
                    state_next = S_FINISH;
                end else begin
                    state_next = S_FETCH;
                end
            end
            S_FINISH: state_next = S_DONE;
            S_DONE: begin
                if (!m_valid_reg || m_tready) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // ---------------- datapath and outputs ----------------
    always_comb begin
        wp_next        = wp_reg;
        ps_next        = ps_reg;
        level_next     = level_reg;
        flag_next      = flag_reg;
        match_next     = match_reg;
        top_next       = top_reg;
        hit_next       = hit_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        phase_next     = phase_reg;
        cin_next       = cin_reg;
        cout_next      = cout_reg;
        sum_next       = sum_reg;
        e2hi_next      = e2hi_reg;
        acc_next       = acc_reg;
        pen_next       = pen_reg;
        res_valid_next = res_valid_reg;
        m_data_next    = m_data_reg;
        m_user_next    = m_user_reg;
        m_valid_next   = m_tready ? 1'b0 : m_valid_reg;
        mul_req        = '0;
        s_tready       = (state_reg == S_IDLE);

        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    sum_next       = '0;
                    res_valid_next = 1'b0;
                    if (in_op == OP_PACKET) begin
                        wp_next  = (wp_inc >= len_act) ? '0 : wp_inc[IDX_W-1:0];
                        ps_next  = (ps_reg < len_act) ? ps_reg + LEN_W'(1) : len_act;
                        hit_next = (in_size == mcs_reg);
                    end
                end
            end
            S_MARK_MUL: begin
                mul_req.op_a = {8'b0, level_reg};
                mul_req.op_b = {7'b0, gain_comp};
            end
            S_MARK_UPD: begin
                level_next = lv_sat;
                flag_next  = flag_reg || (lv_sat > mthr_reg);
                i_next     = '0;
                j_next     = wp_reg;
                phase_next = 1'b0;
                cin_next   = '0;
                cout_next  = '0;
            end
            S_CUM: begin
                if (pkt_rd.outgoing) begin
                    cout_next = cout_reg + 22'(pkt_rd.size);
                end else begin
                    cin_next = cin_reg + 22'(pkt_rd.size);
                end
                sum_next = sat48(54'(sum_reg) + 54'(tmpl_rd_reg.bias));
            end
            S_SQ: begin
                mul_req.op_a = {2'b0, err_abs};
                mul_req.op_b = {2'b0, err_abs};
            end
            S_LO: begin
                mul_req.op_a = {2'b0, mul_prod[21:0]};
                mul_req.op_b = sel_scale;
                e2hi_next    = mul_prod[43:22];
            end
            S_HI: begin
                mul_req.op_a = {2'b0, e2hi_reg};
                mul_req.op_b = sel_scale;
                acc_next     = mul_prod[46:0] + 47'd32768;
            end
            S_PEN: begin
                pen_next = pen_full[67:16];
            end
            S_APPLY: begin
                sum_next = sat48(54'(sum_reg) - $signed({2'b0, pen_reg}));
                if (!phase_reg) begin
                    phase_next = 1'b1;
                end else begin
                    phase_next = 1'b0;
                    i_next     = i_reg + IDX_W'(1);
                    j_next     = j_step;
                end
            end
            S_FINISH: begin
                res_valid_next = 1'b1;
                if (sum_reg > top_reg) begin
                    top_next = sum_reg;
                end
                match_next = (sum_reg > xthr_reg);
            end
            S_DONE: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_user_next  = res_valid_reg;
                    m_data_next  = {6'b0, top_reg, sum_reg, match_reg, flag_reg};
                end
            end
            default: ;
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            wp_reg      <= '0;
            ps_reg      <= '0;
            level_reg   <= '0;
            flag_reg    <= 1'b0;
            match_reg   <= 1'b0;
            top_reg     <= MIN48;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            wp_reg      <= wp_next;
            ps_reg      <= ps_next;
            level_reg   <= level_next;
            flag_reg    <= flag_next;
            match_reg   <= match_next;
            top_reg     <= top_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        hit_reg       <= hit_next;
        i_reg         <= i_next;
        j_reg         <= j_next;
        phase_reg     <= phase_next;
        cin_reg       <= cin_next;
        cout_reg      <= cout_next;
        sum_reg       <= sum_next;
        e2hi_reg      <= e2hi_next;
        acc_reg       <= acc_next;
        pen_reg       <= pen_next;
        res_valid_reg <= res_valid_next;
        m_data_reg    <= m_data_next;
        m_user_reg    <= m_user_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

    // ---------------- assertions ----------------
    a_flag_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        flag_reg |=> flag_reg)
        else $error("marker flag cleared after being set");

    a_scored_needs_marker: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |-> m_tdata[0])
        else $error("score reported without marker flag");

    a_best_monotonic: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_FINISH) |=> (top_reg >= $past(top_reg)))
        else $error("best score decreased");

    a_seen_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        ps_reg <= LEN_W'(DEPTH))
        else $error("packet count beyond window depth");

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("sequencer ready right after a transaction");

endmodule

`default_nettype wire

@@ bench/tb_top.sv @@
// Self-checking bench for flow_template_match_scorer: directed and random flow traffic.
`default_nettype none

module tb_top;
    import ftms_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // One slave-side transaction, unpacked by field.
    typedef struct {
        logic               op;
        logic [15:0]        size;
        logic               outgoing;
        logic [5:0]         idx;
        logic [21:0]        mean_in;
        logic [21:0]        mean_out;
        logic [23:0]        scale_in;
        logic [23:0]        scale_out;
        logic signed [23:0] bias;
    } flow_item_t;

    // One master-side transaction, unpacked by field.
    typedef struct {
        logic               marker_seen;
        logic               score_valid;
        logic               match_flag;
        logic signed [47:0] score;
        logic signed [47:0] best;
    } flow_result_t;

    localparam int ITEM_TARGET = 1850;
    localparam int IDLE_PCT    = 18;

    // DUT ports
    logic         aclk;
    logic         aresetn;
    logic         cfg_we;
    logic [2:0]   cfg_addr;
    logic [47:0]  cfg_wdata;
    logic         s_tvalid;
    logic         s_tready;
    logic [143:0] s_tdata;
    logic         s_tuser;
    logic         m_tvalid;
    logic         m_tready;
    logic [103:0] m_tdata;
    logic         m_tuser;

    // Predictor copy of the configuration.
    logic [6:0]         win_len;
    logic [15:0]        cell_size;
    logic [15:0]        avg_gain;
    logic [15:0]        marker_thr;
    logic signed [47:0] match_thr;

    // Predictor copy of the block state.
    logic [15:0]        ring_size [DEPTH];
    logic               ring_out  [DEPTH];
    logic [21:0]        tmpl_mean_in   [DEPTH];
    logic [21:0]        tmpl_mean_out  [DEPTH];
    logic [23:0]        tmpl_scale_in  [DEPTH];
    logic [23:0]        tmpl_scale_out [DEPTH];
    logic signed [23:0] tmpl_bias      [DEPTH];
    int unsigned        wr_ptr;
    int unsigned        fill_count;
    int unsigned        avg_level;
    logic               seen_flag;
    logic               match_hit;
    longint             best_seen;

    flow_result_t pending_results[$];

    // Bookkeeping.
    int  errors;
    int  items_sent;
    int  packets_sent;
    int  entries_sent;
    int  scored_seen;
    int  matches_seen;
    int  phases_run;
    int  max_window;
    bit  no_idle;

    flow_template_match_scorer u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    initial begin
        aclk = 1'b0;
    end

    always #5 aclk = ~aclk;

    // Generous cap: even with every packet scoring at the full 64-deep window and
    // worst-case stalls the planned traffic finishes well inside this.
    initial begin
        #40ms;
        $display("TEST FAILED");
        $finish;
    end

    // Master-side backpressure, changed on the falling edge.
    always @(negedge aclk) begin
        m_tready <= no_idle || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    function automatic longint clamp48(longint v);
        longint r;
        r = v;
        if (v > longint'(MAX48)) begin
            r = longint'(MAX48);
        end else if (v < longint'(MIN48)) begin
            r = longint'(MIN48);
        end
        return r;
    endfunction

    // (mean - cum)^2 * scale, scale in Q8.16, with the Q.16 product rounded half up to Q.0.
    function automatic longint error_penalty(logic [21:0] mean, longint cum,
                                             logic [23:0] scale);
        longint     e;
        logic [63:0] a;
        logic [63:0] e2;
        logic [63:0] s;
        logic [63:0] q;
        e  = longint'(mean) - cum;
        a  = (e < 0) ? -e : e;
        e2 = a * a;
        s  = 64'(scale);
        q  = (e2 >> 16) * s + (((e2 & 64'hFFFF) * s + 64'd32768) >> 16);
        return longint'(q);
    endfunction

    // Applies one transaction to the predictor state and returns the result it yields.
    function automatic flow_result_t advance_flow(flow_item_t it);
        flow_result_t r;
        int unsigned  len;
        int unsigned  j;
        logic [63:0]  lv;
        longint       cum_in;
        longint       cum_out;
        longint       acc;
        r.score_valid = 1'b0;
        r.score       = '0;
        if (it.op == OP_PACKET) begin
            len = (win_len == 0) ? 1 : ((win_len > DEPTH) ? DEPTH : win_len);
            // a shrunk window wraps the pointer before the write
            if (wr_ptr >= len) begin
                wr_ptr = 0;
            end
            ring_size[wr_ptr] = it.size;
            ring_out[wr_ptr]  = it.outgoing;
            wr_ptr++;
            if (wr_ptr >= len) begin
                wr_ptr = 0;
            end
            if (fill_count < len) begin
                fill_count++;
            end
            if (fill_count > len) begin
                fill_count = len;
            end

            lv = 64'(avg_level) * (64'd65536 - 64'(avg_gain)) + 64'd32768;
            if (it.size == cell_size) begin
                lv += 64'(avg_gain) << 16;
            end
            lv >>= 16;
            if (lv > 64'hFFFF) begin
                lv = 64'hFFFF;
            end
            avg_level = int'(lv[15:0]);
            if (avg_level > marker_thr) begin
                seen_flag = 1'b1;
            end

            if (seen_flag && fill_count >= len) begin
                cum_in  = 0;
                cum_out = 0;
                acc     = 0;
                j       = wr_ptr;
                // oldest to newest
                for (int i = 0; i < len; i++) begin
                    if (ring_out[j]) begin
                        cum_out += longint'(ring_size[j]);
                    end else begin
                        cum_in += longint'(ring_size[j]);
                    end
                    acc = clamp48(acc + longint'(tmpl_bias[i]));
                    acc = clamp48(acc - error_penalty(tmpl_mean_in[i], cum_in,
                                                      tmpl_scale_in[i]));
                    acc = clamp48(acc - error_penalty(tmpl_mean_out[i], cum_out,
                                                      tmpl_scale_out[i]));
                    j++;
                    if (j >= len) begin
                        j = 0;
                    end
                end
                r.score_valid = 1'b1;
                r.score       = acc[47:0];
                if (acc > best_seen) begin
                    best_seen = acc;
                end
                match_hit = acc > longint'(match_thr);
            end
        end else begin
            tmpl_mean_in[it.idx]   = it.mean_in;
            tmpl_mean_out[it.idx]  = it.mean_out;
            tmpl_scale_in[it.idx]  = it.scale_in;
            tmpl_scale_out[it.idx] = it.scale_out;
            tmpl_bias[it.idx]      = it.bias;
        end
        r.marker_seen = seen_flag;
        r.match_flag  = match_hit;
        r.best        = best_seen[47:0];
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Result checker: every master-side transaction against the oldest prediction
    // ------------------------------------------------------------------

    always @(posedge aclk) begin : check_results
        flow_result_t exp_r;
        logic signed [47:0] act_score;
        logic signed [47:0] act_best;
        if (aresetn && m_tvalid && m_tready) begin
            act_score = m_tdata[49:2];
            act_best  = m_tdata[97:50];
            if (m_tuser) begin
                scored_seen++;
                if (m_tdata[1]) begin
                    matches_seen++;
                end
            end
            if (pending_results.size() == 0) begin
                errors++;
                $display("%0t: unexpected result transaction, score_valid %0b score %0d",
                         $time, m_tuser, act_score);
            end else begin
                exp_r = pending_results.pop_front();
                if (m_tdata[0] !== exp_r.marker_seen) begin
                    errors++;
                    $display("%0t: marker_seen expected %0b actual %0b",
                             $time, exp_r.marker_seen, m_tdata[0]);
                end
                if (m_tuser !== exp_r.score_valid) begin
                    errors++;
                    $display("%0t: score_valid expected %0b actual %0b",
                             $time, exp_r.score_valid, m_tuser);
                end
                if (m_tdata[1] !== exp_r.match_flag) begin
                    errors++;
                    $display("%0t: match_flag expected %0b actual %0b",
                             $time, exp_r.match_flag, m_tdata[1]);
                end
                if (act_score !== exp_r.score) begin
                    errors++;
                    $display("%0t: match_score expected %0d actual %0d",
                             $time, exp_r.score, act_score);
                end
                if (act_best !== exp_r.best) begin
                    errors++;
                    $display("%0t: best_score expected %0d actual %0d",
                             $time, exp_r.best, act_best);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------

    // Sends one transaction, with random idle cycles ahead of it. tvalid stays high
    // after acceptance until the next falling edge decides what comes next.
    task automatic send_item(input flow_item_t it);
        logic [143:0] d;
        while (!no_idle && $urandom_range(0, 99) < IDLE_PCT) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
        end
        d          = '0;
        d[15:0]    = it.size;
        d[16]      = it.outgoing;
        d[22:17]   = it.idx;
        d[44:23]   = it.mean_in;
        d[66:45]   = it.mean_out;
        d[90:67]   = it.scale_in;
        d[114:91]  = it.scale_out;
        d[138:115] = it.bias;
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata  <= d;
        s_tuser  <= it.op;
        do begin
            @(posedge aclk);
        end while (!s_tready);
        pending_results.push_back(advance_flow(it));
        items_sent++;
        if (it.op == OP_PACKET) begin
            packets_sent++;
        end else begin
            entries_sent++;
        end
    endtask

    // Drop tvalid, wait for every prediction to be matched, then let the
    // sequencer settle before touching registers.
    task automatic drain();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) begin
            @(posedge aclk);
        end
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [2:0] addr, input logic [47:0] val);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_addr  <= addr;
        cfg_wdata <= val;
        @(negedge aclk);
        cfg_we    <= 1'b0;
        case (addr)
            CFG_WINDOW_LENGTH: begin
                win_len = val[6:0];
            end
            CFG_MARKER_CELL_SIZE: begin
                cell_size = val[15:0];
            end
            CFG_AVERAGE_GAIN: begin
                avg_gain = val[15:0];
            end
            CFG_MARKER_THRESHOLD: begin
                marker_thr = val[15:0];
            end
            CFG_MATCH_THRESHOLD: begin
                match_thr = val;
            end
            default: begin
            end
        endcase
        if (addr == CFG_WINDOW_LENGTH && val[6:0] > max_window) begin
            max_window = val[6:0];
        end
    endtask

    // ------------------------------------------------------------------
    // Item builders
    // ------------------------------------------------------------------

    // Every field but the opcode random, the scales only up to 8388608; callers overwrite what matters.
    function automatic flow_item_t noise_item();
        flow_item_t it;
        it.op        = OP_PACKET;
        it.size      = 16'($urandom());
        it.outgoing  = 1'($urandom());
        it.idx       = 6'($urandom());
        it.mean_in   = 22'($urandom());
        it.mean_out  = 22'($urandom());
        it.scale_in  = ($urandom_range(0, 49) == 0) ? 24'd8388608
                                                    : 24'($urandom_range(0, 8388607));
        it.scale_out = ($urandom_range(0, 49) == 0) ? 24'd8388608
                                                    : 24'($urandom_range(0, 8388607));
        it.bias      = 24'($urandom());
        return it;
    endfunction

    function automatic flow_item_t packet_item(input logic [15:0] size,
                                               input logic outgoing);
        flow_item_t it;
        it          = noise_item();
        it.op       = OP_PACKET;
        it.size     = size;
        it.outgoing = outgoing;
        return it;
    endfunction

    // Template entry; the tame form tracks the cumulative sizes of typical traffic
    // with small scales so scores land near zero instead of saturating.
    function automatic flow_item_t entry_item(input logic [5:0] idx, input bit wild);
        flow_item_t it;
        int         b;
        it     = noise_item();
        it.op  = OP_TEMPLATE;
        it.idx = idx;
        if (!wild) begin
            b            = int'($urandom_range(0, 12000)) - 6000;
            it.mean_in   = 22'(int'(idx) * 375 + int'($urandom_range(0, 2000)));
            it.mean_out  = 22'(int'(idx) * 375 + int'($urandom_range(0, 2000)));
            it.scale_in  = 24'($urandom_range(0, 48));
            it.scale_out = 24'($urandom_range(0, 48));
            it.bias      = b[23:0];
        end
        return it;
    endfunction

    // Mostly mid-sized traffic, with marker cells, full-range sizes and the extremes.
    function automatic logic [15:0] pick_size();
        int          r;
        logic [15:0] s;
        r = $urandom_range(0, 99);
        if (r < 8) begin
            s = cell_size;
        end else if (r < 18) begin
            s = 16'($urandom());
        end else if (r < 22) begin
            s = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
        end else begin
            s = 16'($urandom_range(40, 1500));
        end
        return s;
    endfunction

    task automatic load_template(input bit wild);
        for (int i = 0; i < DEPTH; i++) begin
            send_item(entry_item(6'(i), wild));
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Every template entry gets written before any window can be scored.
    task automatic test_template_load();
        load_template(1'b0);
        drain();
    endtask

    // Marker average under the reset registers, then saturation and the flag.
    task automatic test_marker_average();
        send_item(packet_item(16'h0000, 1'b0));
        send_item(packet_item(16'hFFFF, 1'b1));
        repeat (3) send_item(packet_item(RST_MARKER_CELL_SIZE, 1'b0));
        send_item(entry_item(6'd5, 1'b0));
        drain();
        // unity gain on max-size cells pins the level at full scale, still not above
        // a full-scale threshold
        write_reg(CFG_MARKER_CELL_SIZE, 48'd65535);
        write_reg(CFG_AVERAGE_GAIN, 48'd65535);
        write_reg(CFG_MARKER_THRESHOLD, 48'd65535);
        send_item(packet_item(16'hFFFF, 1'b1));
        send_item(packet_item(16'hFFFF, 1'b0));
        drain();
        // zero gain holds the level; a threshold just below it raises the flag
        write_reg(CFG_MARKER_CELL_SIZE, 48'd0);
        write_reg(CFG_AVERAGE_GAIN, 48'd0);
        write_reg(CFG_MARKER_THRESHOLD, 48'd65534);
        send_item(packet_item(16'h0000, 1'b0));
        send_item(packet_item(16'd1200, 1'b1));
        drain();
    endtask

    // Window length zero acts as one; threshold extremes force the match flag.
    task automatic test_short_window();
        write_reg(CFG_WINDOW_LENGTH, 48'd0);
        write_reg(CFG_MATCH_THRESHOLD, 48'(MIN48));
        send_item(packet_item(16'd300, 1'b0));
        send_item(packet_item(16'd700, 1'b1));
        drain();
        write_reg(CFG_MATCH_THRESHOLD, 48'(MAX48));
        send_item(packet_item(16'd100, 1'b1));
        send_item(packet_item(16'h0000, 1'b0));
        drain();
        write_reg(CFG_WINDOW_LENGTH, 48'd1);
        write_reg(CFG_MATCH_THRESHOLD, 48'd0);
        send_item(packet_item(16'd500, 1'b0));
        drain();
    endtask

    // Extreme template entries and sizes drive the accumulator into its lower rail.
    task automatic test_field_extremes();
        flow_item_t it;
        write_reg(CFG_WINDOW_LENGTH, 48'd2);
        it           = entry_item(6'd0, 1'b1);
        it.mean_in   = 22'h3FFFFF;
        it.mean_out  = 22'h000000;
        it.scale_in  = 24'd8388608;
        it.scale_out = 24'd0;
        it.bias      = 24'sh7FFFFF;
        send_item(it);
        it           = entry_item(6'd1, 1'b1);
        it.mean_in   = 22'h000000;
        it.mean_out  = 22'h3FFFFF;
        it.scale_in  = 24'd0;
        it.scale_out = 24'd8388608;
        it.bias      = 24'sh800000;
        send_item(it);
        it           = entry_item(6'd63, 1'b1);
        send_item(it);
        send_item(packet_item(16'hFFFF, 1'b0));
        send_item(packet_item(16'hFFFF, 1'b1));
        send_item(packet_item(16'h0000, 1'b1));
        // all-zero penalties leave pure bias sums
        it           = entry_item(6'd0, 1'b1);
        it.scale_in  = 24'd0;
        it.scale_out = 24'd0;
        it.bias      = 24'sh7FFFFF;
        send_item(it);
        it.idx       = 6'd1;
        send_item(it);
        send_item(packet_item(16'd64, 1'b0));
        send_item(entry_item(6'd0, 1'b0));
        send_item(entry_item(6'd1, 1'b0));
        send_item(entry_item(6'd63, 1'b0));
        drain();
    endtask

    // Full depth, out-of-range length, then shrink (pointer wrap) and regrow.
    task automatic test_window_resize();
        write_reg(CFG_WINDOW_LENGTH, 48'd127);
        write_reg(CFG_MATCH_THRESHOLD, -48'sd4000);
        repeat (70) send_item(packet_item(pick_size(), 1'($urandom())));
        drain();
        write_reg(CFG_WINDOW_LENGTH, 48'd5);
        repeat (8) send_item(packet_item(pick_size(), 1'($urandom())));
        drain();
        write_reg(CFG_WINDOW_LENGTH, 48'd9);
        repeat (12) send_item(packet_item(pick_size(), 1'($urandom())));
        drain();
    endtask

    // Random phases: fresh window length and match threshold each time, mostly short windows, a packet
    // stream laced with template rewrites.
    task automatic test_random_traffic();
        int          r;
        int          len;
        int          n_items;
        int          span;
        logic [47:0] thr;
        while (items_sent < ITEM_TARGET) begin
            drain();
            phases_run++;
            no_idle = (phases_run == 4);
            r = $urandom_range(0, 99);
            if (r < 8) begin
                len = 0;
            end else if (r < 14) begin
                len = $urandom_range(65, 127);
            end else if (r < 22) begin
                len = $urandom_range(13, 64);
            end else begin
                len = $urandom_range(1, 12);
            end
            write_reg(CFG_WINDOW_LENGTH, 48'(len));
            r    = $urandom_range(0, 99);
            span = ((len == 0) ? 1 : ((len > DEPTH) ? DEPTH : len)) * 8000;
            if (r < 10) begin
                thr = 48'(MIN48);
            end else if (r < 20) begin
                thr = 48'(MAX48);
            end else begin
                thr = 48'(longint'($urandom_range(0, 2 * span)) - longint'(span));
            end
            write_reg(CFG_MATCH_THRESHOLD, thr);
            // marker registers steer the average, which no longer matters once the flag is sticky
            if ($urandom_range(0, 3) == 0) begin
                write_reg(CFG_MARKER_CELL_SIZE, 48'($urandom_range(0, 65535)));
                write_reg(CFG_AVERAGE_GAIN, 48'($urandom_range(0, 65535)));
                write_reg(CFG_MARKER_THRESHOLD, 48'($urandom_range(0, 65535)));
            end
            if ($urandom_range(0, 3) == 0) begin
                load_template(1'b0);
            end
            n_items = (len > 12) ? $urandom_range(20, 40) : $urandom_range(40, 120);
            repeat (n_items) begin
                if ($urandom_range(0, 9) == 0) begin
                    send_item(entry_item(6'($urandom()), $urandom_range(0, 4) == 0));
                end else begin
                    send_item(packet_item(pick_size(), 1'($urandom())));
                end
            end
        end
        no_idle = 1'b0;
        drain();
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------

    initial begin
        aresetn   = 1'b0;
        cfg_we    = 1'b0;
        cfg_addr  = CFG_WINDOW_LENGTH;
        cfg_wdata = '0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = OP_PACKET;
        m_tready  = 1'b0;
        no_idle   = 1'b0;

        errors       = 0;
        items_sent   = 0;
        packets_sent = 0;
        entries_sent = 0;
        scored_seen  = 0;
        matches_seen = 0;
        phases_run   = 0;
        max_window   = RST_WINDOW_LENGTH;

        win_len    = RST_WINDOW_LENGTH;
        cell_size  = RST_MARKER_CELL_SIZE;
        avg_gain   = RST_AVERAGE_GAIN;
        marker_thr = RST_MARKER_THRESHOLD;
        match_thr  = '0;
        for (int i = 0; i < DEPTH; i++) begin
            ring_size[i]      = '0;
            ring_out[i]       = 1'b0;
            tmpl_mean_in[i]   = '0;
            tmpl_mean_out[i]  = '0;
            tmpl_scale_in[i]  = '0;
            tmpl_scale_out[i] = '0;
            tmpl_bias[i]      = '0;
        end
        wr_ptr     = 0;
        fill_count = 0;
        avg_level  = 0;
        seen_flag  = 1'b0;
        match_hit  = 1'b0;
        best_seen  = longint'(MIN48);

        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_template_load();
        test_marker_average();
        test_short_window();
        test_field_extremes();
        test_window_resize();
        test_random_traffic();

        $display("Covered %0d transactions (%0d packets, %0d template writes) in %0d phases",
                 items_sent, packets_sent, entries_sent, phases_run);
        $display("%0d windows scored, %0d above threshold, window length up to %0d",
                 scored_seen, matches_seen, max_window);
        if (errors == 0 && pending_results.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire
